>>> src/least_requested_window_picker_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the window picker
// Clocked implication checks, held off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LEAST_REQUESTED_WINDOW_PICKER_UNIT_ASSERT_SVH
`define LEAST_REQUESTED_WINDOW_PICKER_UNIT_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent
`define LRWP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent
`define LRWP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lrwp_pkg.sv
// ----------------------------------------------------------------------------
// lrwp_pkg
// Sizes, control word layout and helpers shared by the window picker.
// ----------------------------------------------------------------------------
package lrwp_pkg;

    // Table geometry
    localparam int TABLE_BLOCKS = 256;
    localparam int COUNT_WIDTH  = 16;

    // Field widths fixed by the item format
    localparam int PEER_W   = 8;
    localparam int START_W  = 8;
    localparam int LENGTH_W = 9;

    // Derived widths
    localparam int IDX_W  = $clog2(TABLE_BLOCKS);
    localparam int LEN_W  = $clog2(TABLE_BLOCKS + 1);
    localparam int DIV_W  = (LEN_W > PEER_W + 1) ? LEN_W : PEER_W + 1;
    localparam int WIDE_W = ((LEN_W > LENGTH_W) ? LEN_W : LENGTH_W) + 1;
    localparam int SUM_W  = COUNT_WIDTH + LEN_W;
    localparam int COST_W = SUM_W + 1;
    localparam int STEP_W = 4;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Datapath operations, one per microcode step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV,
        OP_SCAN_INIT,
        OP_RD,
        OP_COMPARE,
        OP_CLAIM_INIT,
        OP_CAN_INIT,
        OP_EMIT
    } dp_op_t;

    // What to do with the counter read issued in this step
    typedef enum logic [1:0] {
        RD_NONE,
        RD_ACC,
        RD_INC,
        RD_DEC
    } rd_kind_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_CANCEL,
        C_REM_GE,
        C_K_MORE,
        C_MORE_WIN,
        C_OUT_BUSY,
        C_COUNT_ZERO
    } cond_t;

    // Control word toward the datapath
    typedef struct packed {
        dp_op_t   op;
        rd_kind_t rd_kind;
    } ctrl_t;

    // Full microcode word
    typedef struct packed {
        ctrl_t             ctrl;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    // Status flags back to the sequencer
    typedef struct packed {
        logic no_input;
        logic is_cancel;
        logic rem_ge;
        logic k_more;
        logic more_win;
        logic out_busy;
        logic count_zero;
    } stat_t;

    // Fit a block index into the start field
    function automatic logic [START_W-1:0] to_start(input logic [IDX_W-1:0] idx);
        logic [IDX_W+START_W-1:0] ext;
        ext = (IDX_W + START_W)'(idx);
        return ext[START_W-1:0];
    endfunction

    // Fit a window length into the length field
    function automatic logic [LENGTH_W-1:0] to_length(input logic [LEN_W-1:0] len);
        logic [LEN_W+LENGTH_W-1:0] ext;
        ext = (LEN_W + LENGTH_W)'(len);
        return ext[LENGTH_W-1:0];
    endfunction

endpackage

>>> src/lrwp_ram.sv
// ----------------------------------------------------------------------------
// lrwp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lrwp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/lrwp_seq.sv
// ----------------------------------------------------------------------------
// lrwp_seq
// Microcode sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
module lrwp_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  lrwp_pkg::stat_t stat,
    output lrwp_pkg::ctrl_t ctrl,
    output logic           req_stall
);

    localparam logic [lrwp_pkg::STEP_W-1:0] ST_IDLE       = lrwp_pkg::STEP_W'(0);
    localparam logic [lrwp_pkg::STEP_W-1:0] ST_DISPATCH   = lrwp_pkg::STEP_W'(1);
    localparam logic [lrwp_pkg::STEP_W-1:0] ST_DIV        = lrwp_pkg::STEP_W'(2);
    localparam logic [lrwp_pkg::STEP_W-1:0] ST_SCAN_INIT  = lrwp_pkg::STEP_W'(3);
    localparam logic [lrwp_pkg::STEP_W-1:0] ST_SCAN       = lrwp_pkg::STEP_W'(4);
    localparam logic [lrwp_pkg::STEP_W-1:0] ST_SCAN_END   = lrwp_pkg::STEP_W'(5);
    localparam logic [lrwp_pkg::STEP_W-1:0] ST_COMPARE    = lrwp_pkg::STEP_W'(6);
    localparam logic [lrwp_pkg::STEP_W-1:0] ST_CLAIM_INIT = lrwp_pkg::STEP_W'(7);
    localparam logic [lrwp_pkg::STEP_W-1:0] ST_CLAIM      = lrwp_pkg::STEP_W'(8);
    localparam logic [lrwp_pkg::STEP_W-1:0] ST_CLAIM_END  = lrwp_pkg::STEP_W'(9);
    localparam logic [lrwp_pkg::STEP_W-1:0] ST_EMIT       = lrwp_pkg::STEP_W'(10);
    localparam logic [lrwp_pkg::STEP_W-1:0] ST_DONE       = lrwp_pkg::STEP_W'(11);
    localparam logic [lrwp_pkg::STEP_W-1:0] ST_CAN_INIT   = lrwp_pkg::STEP_W'(12);
    localparam logic [lrwp_pkg::STEP_W-1:0] ST_CAN_CHK    = lrwp_pkg::STEP_W'(13);
    localparam logic [lrwp_pkg::STEP_W-1:0] ST_CANCEL     = lrwp_pkg::STEP_W'(14);
    localparam logic [lrwp_pkg::STEP_W-1:0] ST_CAN_END    = lrwp_pkg::STEP_W'(15);

    logic [lrwp_pkg::STEP_W-1:0] pc_reg;
    logic [lrwp_pkg::STEP_W-1:0] pc_next;
    lrwp_pkg::ucode_t            uword;
    logic                        take;

    // Build one microcode word
    function automatic lrwp_pkg::ucode_t uw(
        input lrwp_pkg::dp_op_t          op,
        input lrwp_pkg::rd_kind_t        kind,
        input lrwp_pkg::cond_t           cond,
        input logic [lrwp_pkg::STEP_W-1:0] target
    );
        lrwp_pkg::ucode_t w;
        w.ctrl.op      = op;
        w.ctrl.rd_kind = kind;
        w.cond         = cond;
        w.target       = target;
        return w;
    endfunction

    // Control store
    function automatic lrwp_pkg::ucode_t rom(input logic [lrwp_pkg::STEP_W-1:0] pc);
        lrwp_pkg::ucode_t w;
        unique case (pc)
            ST_IDLE:       w = uw(lrwp_pkg::OP_LOAD, lrwp_pkg::RD_NONE,
                                  lrwp_pkg::C_NO_INPUT, ST_IDLE);
            ST_DISPATCH:   w = uw(lrwp_pkg::OP_NOP, lrwp_pkg::RD_NONE,
                                  lrwp_pkg::C_CANCEL, ST_CAN_INIT);
            ST_DIV:        w = uw(lrwp_pkg::OP_DIV, lrwp_pkg::RD_NONE,
                                  lrwp_pkg::C_REM_GE, ST_DIV);
            ST_SCAN_INIT:  w = uw(lrwp_pkg::OP_SCAN_INIT, lrwp_pkg::RD_NONE,
                                  lrwp_pkg::C_NEVER, ST_IDLE);
            ST_SCAN:       w = uw(lrwp_pkg::OP_RD, lrwp_pkg::RD_ACC,
                                  lrwp_pkg::C_K_MORE, ST_SCAN);
            ST_SCAN_END:   w = uw(lrwp_pkg::OP_NOP, lrwp_pkg::RD_NONE,
                                  lrwp_pkg::C_NEVER, ST_IDLE);
            ST_COMPARE:    w = uw(lrwp_pkg::OP_COMPARE, lrwp_pkg::RD_NONE,
                                  lrwp_pkg::C_MORE_WIN, ST_SCAN);
            ST_CLAIM_INIT: w = uw(lrwp_pkg::OP_CLAIM_INIT, lrwp_pkg::RD_NONE,
                                  lrwp_pkg::C_NEVER, ST_IDLE);
            ST_CLAIM:      w = uw(lrwp_pkg::OP_RD, lrwp_pkg::RD_INC,
                                  lrwp_pkg::C_K_MORE, ST_CLAIM);
            ST_CLAIM_END:  w = uw(lrwp_pkg::OP_NOP, lrwp_pkg::RD_NONE,
                                  lrwp_pkg::C_NEVER, ST_IDLE);
            ST_EMIT:       w = uw(lrwp_pkg::OP_EMIT, lrwp_pkg::RD_NONE,
                                  lrwp_pkg::C_OUT_BUSY, ST_EMIT);
            ST_DONE:       w = uw(lrwp_pkg::OP_NOP, lrwp_pkg::RD_NONE,
                                  lrwp_pkg::C_ALWAYS, ST_IDLE);
            ST_CAN_INIT:   w = uw(lrwp_pkg::OP_CAN_INIT, lrwp_pkg::RD_NONE,
                                  lrwp_pkg::C_NEVER, ST_IDLE);
            ST_CAN_CHK:    w = uw(lrwp_pkg::OP_NOP, lrwp_pkg::RD_NONE,
                                  lrwp_pkg::C_COUNT_ZERO, ST_IDLE);
            ST_CANCEL:     w = uw(lrwp_pkg::OP_RD, lrwp_pkg::RD_DEC,
                                  lrwp_pkg::C_K_MORE, ST_CANCEL);
            ST_CAN_END:    w = uw(lrwp_pkg::OP_NOP, lrwp_pkg::RD_NONE,
                                  lrwp_pkg::C_ALWAYS, ST_IDLE);
            default:       w = uw(lrwp_pkg::OP_NOP, lrwp_pkg::RD_NONE,
                                  lrwp_pkg::C_ALWAYS, ST_IDLE);
        endcase
        return w;
    endfunction

    // Fetch and decode the current step
    always_comb
    begin
        uword = rom(pc_reg);
        unique case (uword.cond)
            lrwp_pkg::C_NEVER:      take = 1'b0;
            lrwp_pkg::C_ALWAYS:     take = 1'b1;
            lrwp_pkg::C_NO_INPUT:   take = stat.no_input;
            lrwp_pkg::C_CANCEL:     take = stat.is_cancel;
            lrwp_pkg::C_REM_GE:     take = stat.rem_ge;
            lrwp_pkg::C_K_MORE:     take = stat.k_more;
            lrwp_pkg::C_MORE_WIN:   take = stat.more_win;
            lrwp_pkg::C_OUT_BUSY:   take = stat.out_busy;
            lrwp_pkg::C_COUNT_ZERO: take = stat.count_zero;
            default:                take = 1'b0;
        endcase
        pc_next = take ? uword.target : pc_reg + lrwp_pkg::STEP_W'(1);
    end

    assign ctrl      = uword.ctrl;
    assign req_stall = (pc_reg != ST_IDLE);

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> src/lrwp_datapath.sv
// ----------------------------------------------------------------------------
// lrwp_datapath
// Counter table, divider, window cost accumulator and result register.
// ----------------------------------------------------------------------------
`include "least_requested_window_picker_unit_assert.svh"

module lrwp_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lrwp_pkg::ctrl_t                   ctrl,
    output lrwp_pkg::stat_t                   stat,
    input  logic                              req_valid,
    input  logic                              action,
    input  logic [lrwp_pkg::PEER_W-1:0]       peer_count,
    input  logic [lrwp_pkg::START_W-1:0]      cancel_start,
    input  logic [lrwp_pkg::LENGTH_W-1:0]     cancel_length,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [lrwp_pkg::START_W-1:0]      window_start,
    output logic [lrwp_pkg::LENGTH_W-1:0]     window_length
);

    // Item and loop registers
    logic                               action_reg, action_next;
    logic [lrwp_pkg::START_W-1:0]       cstart_reg, cstart_next;
    logic [lrwp_pkg::LENGTH_W-1:0]      clen_reg, clen_next;
    logic [lrwp_pkg::DIV_W-1:0]         div_reg, div_next;
    logic [lrwp_pkg::DIV_W-1:0]         rem_reg, rem_next;
    logic [lrwp_pkg::LEN_W-1:0]         len_reg, len_next;
    logic [lrwp_pkg::LEN_W-1:0]         k_reg, k_next;
    logic [lrwp_pkg::LEN_W-1:0]         s_reg, s_next;
    logic [lrwp_pkg::IDX_W-1:0]         best_reg, best_next;
    logic [lrwp_pkg::COST_W-1:0]        best_cost_reg, best_cost_next;
    logic                               first_win_reg, first_win_next;
    logic [lrwp_pkg::SUM_W-1:0]         sum_reg, sum_next;
    logic [lrwp_pkg::COUNT_WIDTH-1:0]   min_reg, min_next;

    // Read tag, registered with the RAM read address to line up with the read data
    lrwp_pkg::rd_kind_t                 tag_kind_reg, tag_kind_next;
    logic                               tag_first_reg;
    logic [lrwp_pkg::IDX_W-1:0]         tag_addr_reg;

    // Per-entry written marks
    logic                               valid_reg [lrwp_pkg::TABLE_BLOCKS];
    logic                               valid_rd_reg;

    // Result register
    logic                               rsp_valid_reg, rsp_valid_next;
    logic [lrwp_pkg::START_W-1:0]       rsp_start_reg, rsp_start_next;
    logic [lrwp_pkg::LENGTH_W-1:0]      rsp_len_reg, rsp_len_next;

    // Combinational helpers
    logic [lrwp_pkg::WIDE_W-1:0]        base_w, addr_w, room_w, clen_w, cnt_w;
    logic [lrwp_pkg::IDX_W-1:0]         raddr;
    logic                               re, we;
    logic [lrwp_pkg::COUNT_WIDTH-1:0]   rdata, data_eff, wdata;
    logic [lrwp_pkg::COST_W-1:0]        cost;
    logic                               out_busy;

    // Counter RAM
    lrwp_ram #(
        .WIDTH (lrwp_pkg::COUNT_WIDTH),
        .DEPTH (lrwp_pkg::TABLE_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (tag_addr_reg),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Form the read address from the base that the read kind selects
    always_comb
    begin
        unique case (ctrl.rd_kind)
            lrwp_pkg::RD_INC: base_w = lrwp_pkg::WIDE_W'(best_reg);
            lrwp_pkg::RD_DEC: base_w = lrwp_pkg::WIDE_W'(cstart_reg);
            default:          base_w = lrwp_pkg::WIDE_W'(s_reg);
        endcase
        addr_w = base_w + lrwp_pkg::WIDE_W'(k_reg);
        raddr  = addr_w[lrwp_pkg::IDX_W-1:0];
        re     = (ctrl.op == lrwp_pkg::OP_RD);
    end

    // Unwritten entries read as zero; build the write-back value
    always_comb
    begin
        data_eff = valid_rd_reg ? rdata : '0;
        we       = (tag_kind_reg == lrwp_pkg::RD_INC) || (tag_kind_reg == lrwp_pkg::RD_DEC);
        if (tag_kind_reg == lrwp_pkg::RD_INC)
        begin
            wdata = (data_eff == lrwp_pkg::COUNT_MAX) ? data_eff
                  : data_eff + lrwp_pkg::COUNT_WIDTH'(1);
        end
        else
        begin
            wdata = (data_eff == '0) ? data_eff : data_eff - lrwp_pkg::COUNT_WIDTH'(1);
        end
    end

    // Clip the cancel range to the table
    always_comb
    begin
        room_w = lrwp_pkg::WIDE_W'(lrwp_pkg::TABLE_BLOCKS) - lrwp_pkg::WIDE_W'(cstart_reg);
        clen_w = lrwp_pkg::WIDE_W'(clen_reg);
        if (lrwp_pkg::WIDE_W'(cstart_reg) >= lrwp_pkg::WIDE_W'(lrwp_pkg::TABLE_BLOCKS))
        begin
            cnt_w = '0;
        end
        else if (clen_w < room_w)
        begin
            cnt_w = clen_w;
        end
        else
        begin
            cnt_w = room_w;
        end
    end

    assign cost     = lrwp_pkg::COST_W'(sum_reg) + lrwp_pkg::COST_W'(min_reg);
    assign out_busy = rsp_valid_reg && rsp_stall;

    // Status toward the sequencer
    always_comb
    begin
        stat.no_input   = !req_valid;
        stat.is_cancel  = action_reg;
        stat.rem_ge     = (rem_reg >= div_reg);
        stat.k_more     = (k_reg != (len_reg - lrwp_pkg::LEN_W'(1)));
        stat.more_win   = ((lrwp_pkg::WIDE_W'(s_reg) + lrwp_pkg::WIDE_W'(len_reg))
                          < lrwp_pkg::WIDE_W'(lrwp_pkg::TABLE_BLOCKS));
        stat.out_busy   = out_busy;
        stat.count_zero = (len_reg == '0);
    end

    // Next-state logic for the datapath registers
    always_comb
    begin
        action_next    = action_reg;
        cstart_next    = cstart_reg;
        clen_next      = clen_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        len_next       = len_reg;
        k_next         = k_reg;
        s_next         = s_reg;
        best_next      = best_reg;
        best_cost_next = best_cost_reg;
        first_win_next = first_win_reg;
        sum_next       = sum_reg;
        min_next       = min_reg;
        tag_kind_next  = re ? ctrl.rd_kind : lrwp_pkg::RD_NONE;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_start_next = rsp_start_reg;
        rsp_len_next   = rsp_len_reg;

        // Fold in the counter read issued last cycle
        if (tag_kind_reg == lrwp_pkg::RD_ACC)
        begin
            if (tag_first_reg)
            begin
                sum_next = lrwp_pkg::SUM_W'(data_eff);
                min_next = data_eff;
            end
            else
            begin
                sum_next = sum_reg + lrwp_pkg::SUM_W'(data_eff);
                min_next = (data_eff < min_reg) ? data_eff : min_reg;
            end
        end

        unique case (ctrl.op)
            lrwp_pkg::OP_LOAD:
            begin
                // Capture an item and set up the length division
                if (req_valid)
                begin
                    action_next = action;
                    cstart_next = cancel_start;
                    clen_next   = cancel_length;
                    div_next    = lrwp_pkg::DIV_W'(peer_count) + lrwp_pkg::DIV_W'(1);
                    rem_next    = lrwp_pkg::DIV_W'(lrwp_pkg::TABLE_BLOCKS);
                    len_next    = '0;
                end
            end
            lrwp_pkg::OP_DIV:
            begin
                // One subtraction per step
                if (rem_reg >= div_reg)
                begin
                    rem_next = rem_reg - div_reg;
                    len_next = len_reg + lrwp_pkg::LEN_W'(1);
                end
            end
            lrwp_pkg::OP_SCAN_INIT:
            begin
                s_next         = '0;
                k_next         = '0;
                first_win_next = 1'b1;
            end
            lrwp_pkg::OP_RD:
            begin
                k_next = k_reg + lrwp_pkg::LEN_W'(1);
            end
            lrwp_pkg::OP_COMPARE:
            begin
                // Keep the first window with the lowest cost
                if (first_win_reg || (cost < best_cost_reg))
                begin
                    best_next      = s_reg[lrwp_pkg::IDX_W-1:0];
                    best_cost_next = cost;
                end
                s_next         = s_reg + lrwp_pkg::LEN_W'(1);
                k_next         = '0;
                first_win_next = 1'b0;
            end
            lrwp_pkg::OP_CLAIM_INIT:
            begin
                k_next = '0;
            end
            lrwp_pkg::OP_CAN_INIT:
            begin
                k_next   = '0;
                len_next = cnt_w[lrwp_pkg::LEN_W-1:0];
            end
            lrwp_pkg::OP_EMIT:
            begin
                if (!out_busy)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_start_next = lrwp_pkg::to_start(best_reg);
                    rsp_len_next   = lrwp_pkg::to_length(len_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_kind_reg  <= lrwp_pkg::RD_NONE;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < lrwp_pkg::TABLE_BLOCKS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            tag_kind_reg  <= tag_kind_next;
            rsp_valid_reg <= rsp_valid_next;
            if (we)
            begin
                valid_reg[tag_addr_reg] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        action_reg    <= action_next;
        cstart_reg    <= cstart_next;
        clen_reg      <= clen_next;
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        len_reg       <= len_next;
        k_reg         <= k_next;
        s_reg         <= s_next;
        best_reg      <= best_next;
        best_cost_reg <= best_cost_next;
        first_win_reg <= first_win_next;
        sum_reg       <= sum_next;
        min_reg       <= min_next;
        rsp_start_reg <= rsp_start_next;
        rsp_len_reg   <= rsp_len_next;
        if (re)
        begin
            tag_first_reg <= (k_reg == '0);
            tag_addr_reg  <= raddr;
            valid_rd_reg  <= valid_reg[raddr];
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign window_start  = rsp_start_reg;
    assign window_length = rsp_len_reg;

    // The division always yields a window of at least one block
    `LRWP_ASSERT_SAME(a_len_nonzero, clk, rst_n, ctrl.op == lrwp_pkg::OP_SCAN_INIT,
        len_reg != '0, "window length is zero at scan start")

    // Every read stays inside the current run
    `LRWP_ASSERT_SAME(a_k_in_run, clk, rst_n, ctrl.op == lrwp_pkg::OP_RD,
        k_reg < len_reg, "read offset beyond run length")

    // Scanned windows fit in the table
    `LRWP_ASSERT_SAME(a_scan_fits, clk, rst_n,
        ctrl.op == lrwp_pkg::OP_COMPARE,
        (32'(s_reg) + 32'(len_reg)) <= 32'(lrwp_pkg::TABLE_BLOCKS),
        "scanned window runs past the table")

    // A write-back follows exactly one issued read
    `LRWP_ASSERT_NEXT(a_wb_follows_read, clk, rst_n,
        (ctrl.op == lrwp_pkg::OP_RD) && (ctrl.rd_kind != lrwp_pkg::RD_ACC),
        we && (tag_addr_reg == $past(raddr)), "write-back lost after read")

    // The chosen window fits in the table
    `LRWP_ASSERT_SAME(a_best_fits, clk, rst_n, ctrl.op == lrwp_pkg::OP_EMIT,
        (32'(best_reg) + 32'(len_reg)) <= 32'(lrwp_pkg::TABLE_BLOCKS),
        "chosen window runs past the table")

endmodule

>>> src/least_requested_window_picker_unit.sv
// ----------------------------------------------------------------------------
// least_requested_window_picker_unit
// Picks the least requested window of blocks and tracks request counts.
//
//   channel   direction   handshake            fields
//   req       in          req_valid/req_stall  action, peer_count,
//                                              cancel_start, cancel_length
//   rsp       out         rsp_valid/rsp_stall  window_start, window_length
//
// A pick finds the window length L by L division steps, then reads the
// counters of every block in each of the W = 256 - L + 1 windows, claims
// the chosen window and emits it. A cancel decrements the counters of
// the blocks in range. The single read port of the counter RAM, read once
// per block per window, sets the time that a pick takes.
// Reset clears all counters at once through per-entry written marks.
// A stalled result holds in the output register; a new item is taken while
// it waits, and the next pick holds at its end until the register is free.
// ----------------------------------------------------------------------------
module least_requested_window_picker_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          action,
    input  logic [lrwp_pkg::PEER_W-1:0]   peer_count,
    input  logic [lrwp_pkg::START_W-1:0]  cancel_start,
    input  logic [lrwp_pkg::LENGTH_W-1:0] cancel_length,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [lrwp_pkg::START_W-1:0]  window_start,
    output logic [lrwp_pkg::LENGTH_W-1:0] window_length
);

    lrwp_pkg::ctrl_t ctrl;
    lrwp_pkg::stat_t stat;

    // Step sequencer
    lrwp_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .ctrl      (ctrl),
        .req_stall (req_stall)
    );

    // Datapath and counter table
    lrwp_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .req_valid     (req_valid),
        .action        (action),
        .peer_count    (peer_count),
        .cancel_start  (cancel_start),
        .cancel_length (cancel_length),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .window_start  (window_start),
        .window_length (window_length)
    );

endmodule
